FILE: src/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tds_pkg.sv
// Shared types and constants of the tridiagonal solver.
// Depends on nothing; imported by tds_alu, tridiagonal_thomas_solver and the testbench.
package tds_pkg;

    localparam int W          = 48;
    localparam int FRAC_BITS  = 32;
    localparam int MAX_POINTS = 64;
    localparam int MIN_POINTS = 3;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CFG_W      = 7;

    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RHS  = 1'b1;

    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [5:0]              index;
        logic signed [W-1:0]     diag_coef;
        logic signed [W-1:0]     upper_coef;
        logic signed [W-1:0]     lower_coef;
        logic signed [W-1:0]     rhs_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]              result_index;
        logic signed [W-1:0]     solution_value;
        logic                    saturated;
        logic                    last_result;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_alu_rsp;

endpackage

FILE: src/tridiagonal_thomas_solver.sv
// Coefficient rows and right-hand-side words are worked on by the shared multiply and the
// two-bit-per-cycle divider. After the last right-hand-side word the back sweep runs over
// the rows, then n solution words follow; one word is in work at a time.
// Reset is synchronous and active low; it clears control state and sets the size to 64,
// while the coefficient and work memories keep whatever they held.
module tridiagonal_thomas_solver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tds_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tds_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tds_pkg::CFG_W-1:0]  i_cfg_data
);
    import tds_pkg::*;
    `include "assert_macros.svh"

    // One coefficient memory row holds the factored pivot, the upper ratio and
    // the lower coefficient linking the row to the next one.
    typedef struct packed {
        logic signed [W-1:0] pivot;
        logic signed [W-1:0] ratio;
        logic signed [W-1:0] lower;
    } t_coef_row;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LD_RD   = 5'd1;
    localparam logic [4:0] S_LD_MUL  = 5'd2;
    localparam logic [4:0] S_LD_MULW = 5'd3;
    localparam logic [4:0] S_LD_DIV  = 5'd4;
    localparam logic [4:0] S_LD_DIVW = 5'd5;
    localparam logic [4:0] S_LD_WR   = 5'd6;
    localparam logic [4:0] S_RH_RDL  = 5'd7;
    localparam logic [4:0] S_RH_MUL  = 5'd8;
    localparam logic [4:0] S_RH_MULW = 5'd9;
    localparam logic [4:0] S_RH_RDP  = 5'd10;
    localparam logic [4:0] S_RH_DIV  = 5'd11;
    localparam logic [4:0] S_RH_DIVW = 5'd12;
    localparam logic [4:0] S_RH_WR   = 5'd13;
    localparam logic [4:0] S_BS_RD   = 5'd14;
    localparam logic [4:0] S_BS_MUL  = 5'd15;
    localparam logic [4:0] S_BS_MULW = 5'd16;
    localparam logic [4:0] S_BS_WR   = 5'd17;
    localparam logic [4:0] S_EX0     = 5'd18;
    localparam logic [4:0] S_EX_RD1  = 5'd19;
    localparam logic [4:0] S_EX_RD2  = 5'd20;
    localparam logic [4:0] S_EX1     = 5'd21;
    localparam logic [4:0] S_OUT_RD  = 5'd22;
    localparam logic [4:0] S_OUT_LD  = 5'd23;
    localparam logic [4:0] S_OUT_WT  = 5'd24;

    // Control state.
    logic [4:0]       r_state;
    logic [CFG_W-1:0] r_point_count;
    logic             r_seen;
    logic             r_factor;
    logic             r_out_valid;

    // Running values of the two sweeps.
    logic signed [W-1:0] r_run_ratio, r_run_value;

    // Payload of the word in work.
    logic [IDX_W-1:0]    r_idx, r_k;
    logic signed [W-1:0] r_diag, r_upper, r_lower, r_rhs;
    logic signed [W-1:0] r_piv, r_num, r_cur, r_prev, r_wk, r_a;
    t_out_item           r_out_item;

    // Memories.
    t_coef_row           coef_mem [MAX_POINTS];
    logic signed [W-1:0] work_mem [MAX_POINTS];
    t_coef_row           r_cm_q;
    logic signed [W-1:0] r_wm_q;
    logic [IDX_W-1:0]    cm_ra, wm_ra, wm_wa;
    logic                cm_we, cm_we_ratio, wm_we;
    logic signed [W-1:0] wm_wd;

    // Arithmetic unit.
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;
    logic signed [W-1:0] alu_a, alu_b, alu_res;

    logic [CFG_W-1:0]    sys_size;
    logic [IDX_W-1:0]    last_idx;
    logic                idx_ok, r_is_last;
    logic signed [W-1:0] sub_a, sub_res, ex_x, ex_y, ex_res;
    logic signed [W+1:0] sub_v, ex_v;
    logic                sub_ovf, ex_ovf;

    function automatic logic signed [W+1:0] sx(input logic signed [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    function automatic logic over_w(input logic signed [W+1:0] v);
        return (v > sx(VAL_MAX)) || (v < sx(VAL_MIN));
    endfunction

    function automatic logic signed [W-1:0] clamp_w(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        r = v[W-1:0];
        if (v > sx(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (v < sx(VAL_MIN)) begin
            r = VAL_MIN;
        end
        return r;
    endfunction

    // The configured size is used clamped to the supported range.
    always_comb begin
        if (r_point_count < CFG_W'(MIN_POINTS)) begin
            sys_size = CFG_W'(MIN_POINTS);
        end else if (r_point_count > CFG_W'(MAX_POINTS)) begin
            sys_size = CFG_W'(MAX_POINTS);
        end else begin
            sys_size = r_point_count;
        end
    end

    assign last_idx  = IDX_W'(sys_size - 1'b1);
    assign idx_ok    = {1'b0, i_in_item.index} < sys_size;
    assign r_is_last = (r_idx == last_idx);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Saturating difference after a product: pivot, forward and back sweep.
    always_comb begin
        case (r_state)
            S_LD_MULW: sub_a = r_diag;
            S_RH_MULW: sub_a = r_rhs;
            default:   sub_a = r_wk;
        endcase
    end

    assign sub_v   = sx(sub_a) - sx(alu_res);
    assign sub_ovf = over_w(sub_v);
    assign sub_res = clamp_w(sub_v);

    // Linear extrapolation of the end points: 2*x - y.
    always_comb begin
        if (r_state == S_EX0) begin
            ex_x = r_cur;
            ex_y = r_prev;
        end else begin
            ex_x = r_a;
            ex_y = r_wm_q;
        end
    end

    assign ex_v   = (sx(ex_x) <<< 1) - sx(ex_y);
    assign ex_ovf = over_w(ex_v);
    assign ex_res = clamp_w(ex_v);

    // Operand selection for the shared multiply and divide unit.
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            S_LD_MUL: begin
                alu_req.start = 1'b1;
                alu_a         = r_cm_q.lower;
                alu_b         = r_run_ratio;
            end
            S_RH_MUL: begin
                alu_req.start = 1'b1;
                alu_a         = r_cm_q.lower;
                alu_b         = r_run_value;
            end
            S_BS_MUL: begin
                alu_req.start = 1'b1;
                alu_a         = r_cm_q.ratio;
                alu_b         = r_cur;
            end
            S_LD_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a         = r_upper;
                alu_b         = r_piv;
            end
            S_RH_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a         = r_num;
                alu_b         = r_cm_q.pivot;
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    tds_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    // Memory addressing. Reads are issued every cycle and registered; a state that needs
    // the data samples it in the cycle after the one that set the address.
    always_comb begin
        case (r_state)
            S_LD_RD, S_RH_RDL: cm_ra = r_idx - 1'b1;
            S_BS_RD:           cm_ra = r_k;
            default:           cm_ra = r_idx;
        endcase
    end

    always_comb begin
        case (r_state)
            S_EX_RD1: wm_ra = IDX_W'(sys_size - 2'd2);
            S_EX_RD2: wm_ra = IDX_W'(sys_size - 2'd3);
            default:  wm_ra = r_k;
        endcase
    end

    assign cm_we       = (r_state == S_LD_WR);
    assign cm_we_ratio = !r_is_last;

    always_comb begin
        wm_we = 1'b1;
        wm_wa = r_k;
        wm_wd = r_cur;
        case (r_state)
            S_RH_WR: wm_wa = r_idx;
            S_BS_WR: wm_wa = r_k;
            S_EX0: begin
                wm_wa = '0;
                wm_wd = ex_res;
            end
            S_EX1: begin
                wm_wa = last_idx;
                wm_wd = ex_res;
            end
            default: wm_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            coef_mem[r_idx].pivot <= r_piv;
            coef_mem[r_idx].lower <= r_lower;
            if (cm_we_ratio) begin
                coef_mem[r_idx].ratio <= r_run_ratio;
            end
        end
        r_cm_q <= coef_mem[cm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wm_we) begin
            work_mem[wm_wa] <= wm_wd;
        end
        r_wm_q <= work_mem[wm_ra];
    end

    // Sequencer: factoring on coefficient rows, the forward sweep on each
    // right-hand-side word, and after the last one the back sweep, the end
    // point extrapolation and the output of the solution run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= CFG_W'(MAX_POINTS);
            r_run_ratio   <= '0;
            r_run_value   <= '0;
            r_seen        <= 1'b0;
            r_factor      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_point_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= i_in_item.index;
                        r_diag  <= i_in_item.diag_coef;
                        r_upper <= i_in_item.upper_coef;
                        r_lower <= i_in_item.lower_coef;
                        r_rhs   <= i_in_item.rhs_value;
                        r_num   <= i_in_item.rhs_value;
                        r_piv   <= i_in_item.diag_coef;
                        // A word whose index lies beyond the system is dropped.
                        if (idx_ok) begin
                            if (i_in_item.operation == OP_LOAD) begin
                                if (i_in_item.index == '0) begin
                                    r_factor <= 1'b0;
                                    r_seen   <= 1'b0;
                                    r_state  <= S_LD_DIV;
                                end else begin
                                    r_state <= S_LD_RD;
                                end
                            end else begin
                                if (i_in_item.index == '0) begin
                                    r_seen  <= r_factor;
                                    r_state <= S_RH_RDP;
                                end else begin
                                    r_state <= S_RH_RDL;
                                end
                            end
                        end
                    end
                end
                S_LD_RD:  r_state <= S_LD_MUL;
                S_LD_MUL: r_state <= S_LD_MULW;
                S_LD_MULW: begin
                    if (alu_rsp.done) begin
                        r_piv <= sub_res;
                        if (alu_rsp.sat || sub_ovf) begin
                            r_factor <= 1'b1;
                            r_seen   <= 1'b1;
                        end
                        r_state <= r_is_last ? S_LD_WR : S_LD_DIV;
                    end
                end
                S_LD_DIV: r_state <= S_LD_DIVW;
                S_LD_DIVW: begin
                    if (alu_rsp.done) begin
                        r_run_ratio <= alu_res;
                        if (alu_rsp.sat) begin
                            r_factor <= 1'b1;
                            r_seen   <= 1'b1;
                        end
                        r_state <= S_LD_WR;
                    end
                end
                S_LD_WR:  r_state <= S_IDLE;
                S_RH_RDL: r_state <= S_RH_MUL;
                S_RH_MUL: r_state <= S_RH_MULW;
                S_RH_MULW: begin
                    if (alu_rsp.done) begin
                        r_num <= sub_res;
                        if (alu_rsp.sat || sub_ovf) begin
                            r_seen <= 1'b1;
                        end
                        r_state <= S_RH_RDP;
                    end
                end
                S_RH_RDP: r_state <= S_RH_DIV;
                S_RH_DIV: r_state <= S_RH_DIVW;
                S_RH_DIVW: begin
                    if (alu_rsp.done) begin
                        r_cur       <= alu_res;
                        r_run_value <= alu_res;
                        if (alu_rsp.sat) begin
                            r_seen <= 1'b1;
                        end
                        r_state <= S_RH_WR;
                    end
                end
                S_RH_WR: begin
                    if (r_is_last) begin
                        r_k     <= IDX_W'(sys_size - 2'd2);
                        r_state <= S_BS_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_BS_RD: r_state <= S_BS_MUL;
                S_BS_MUL: begin
                    r_wk    <= r_wm_q;
                    r_state <= S_BS_MULW;
                end
                S_BS_MULW: begin
                    if (alu_rsp.done) begin
                        r_prev <= r_cur;
                        r_cur  <= sub_res;
                        if (alu_rsp.sat || sub_ovf) begin
                            r_seen <= 1'b1;
                        end
                        r_state <= S_BS_WR;
                    end
                end
                S_BS_WR: begin
                    if (r_k == IDX_W'(1)) begin
                        r_state <= S_EX0;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_BS_RD;
                    end
                end
                S_EX0: begin
                    if (ex_ovf) begin
                        r_seen <= 1'b1;
                    end
                    r_state <= S_EX_RD1;
                end
                S_EX_RD1: r_state <= S_EX_RD2;
                S_EX_RD2: begin
                    r_a     <= r_wm_q;
                    r_state <= S_EX1;
                end
                S_EX1: begin
                    if (ex_ovf) begin
                        r_seen <= 1'b1;
                    end
                    r_k     <= '0;
                    r_state <= S_OUT_RD;
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_out_item.result_index   <= r_k;
                    r_out_item.solution_value <= r_wm_q;
                    r_out_item.saturated      <= r_seen;
                    r_out_item.last_result    <= (r_k == last_idx);
                    r_out_valid               <= 1'b1;
                    r_state                   <= S_OUT_WT;
                end
                S_OUT_WT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_k == last_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A new word is never taken while a solution word is still offered.
    `TDS_ASSERT(a_ready_excl, !(o_in_ready && o_out_valid), "input taken during output run")
    // The last flag marks exactly the element at the top index of the system.
    `TDS_ASSERT(a_last_flag, o_out_valid |-> (o_out_item.last_result == (o_out_item.result_index == last_idx)), "last flag misplaced")
    // The arithmetic unit only answers while the sequencer waits for it.
    `TDS_ASSERT(a_alu_wait, alu_rsp.done |-> (r_state == S_LD_MULW || r_state == S_LD_DIVW || r_state == S_RH_MULW || r_state == S_RH_DIVW || r_state == S_BS_MULW), "unexpected arithmetic result")
    // A run does not return to idle before its last element has gone out.
    `TDS_ASSERT_NEXT(a_run_cont, o_out_valid && i_out_ready && !o_out_item.last_result, !o_in_ready, "output run ended early")

endmodule

FILE: src/tds_alu.sv
// Shared fixed-point multiply and divide unit with rounding and saturation.
// Depends on tds_pkg.
module tds_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tds_pkg::t_alu_req             i_req,
    input  logic signed [tds_pkg::W-1:0]  i_a,
    input  logic signed [tds_pkg::W-1:0]  i_b,
    output tds_pkg::t_alu_rsp             o_rsp,
    output logic signed [tds_pkg::W-1:0]  o_result
);
    import tds_pkg::*;

    localparam int H        = W / 2;
    localparam int PW       = 2 * W;
    localparam int RW       = PW - FRAC_BITS;
    localparam int DIV_BITS = 2;
    localparam int DIV_CYC  = W / DIV_BITS;
    localparam int SW       = $clog2(DIV_CYC + 1);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_MFIN = 3'd2;
    localparam logic [2:0] A_DCHK = 3'd3;
    localparam logic [2:0] A_DIV  = 3'd4;
    localparam logic [2:0] A_DFIN = 3'd5;

    localparam logic [SW-1:0] MUL_LAST = SW'(4);
    localparam logic [SW-1:0] DIV_LAST = SW'(DIV_CYC - 1);
    localparam logic [PW-1:0] HALF     = PW'(1) << (FRAC_BITS - 1);
    localparam logic [RW-1:0] LIM_POS  = RW'(VAL_MAX);
    localparam logic [RW-1:0] LIM_NEG  = RW'(1) << (W - 1);

    logic [2:0]          r_state;
    logic [SW-1:0]       r_step;
    logic [W-1:0]        r_x, r_y;
    logic                r_neg, r_aneg;
    logic [W-1:0]        r_prod;
    logic [1:0]          r_psh;
    logic [PW-1:0]       r_acc;
    logic [W-1:0]        r_rem, r_num, r_q;
    logic signed [W-1:0] r_res;
    logic                r_done, r_sat;

    logic [W-1:0]  a_mag, b_mag;
    logic [H-1:0]  x_part, y_part;
    logic [PW-1:0] prod_sh, msum;
    logic [RW-1:0] mmag;
    logic [W-1:0]  d_rem, d_num, d_q;
    logic [W:0]    d_sh;
    logic          d_ge, rnd;
    logic [W:0]    q1;

    function automatic logic mag_over(input logic [RW-1:0] m, input logic neg);
        return neg ? (m > LIM_NEG) : (m > LIM_POS);
    endfunction

    function automatic logic signed [W-1:0] mag_val(input logic [RW-1:0] m,
                                                    input logic neg);
        logic signed [W-1:0] v;
        v = neg ? W'(~m[W-1:0] + 1'b1) : m[W-1:0];
        if (mag_over(m, neg)) begin
            v = neg ? VAL_MIN : VAL_MAX;
        end
        return v;
    endfunction

    assign a_mag  = i_a[W-1] ? W'(~i_a + 1'b1) : i_a;
    assign b_mag  = i_b[W-1] ? W'(~i_b + 1'b1) : i_b;
    assign x_part = r_step[1] ? r_x[W-1:H] : r_x[H-1:0];
    assign y_part = r_step[0] ? r_y[W-1:H] : r_y[H-1:0];

    always_comb begin
        case (r_psh)
            2'd0:    prod_sh = PW'(r_prod);
            2'd1:    prod_sh = PW'(r_prod) << H;
            default: prod_sh = PW'(r_prod) << (2 * H);
        endcase
    end

    assign msum = r_acc + HALF;
    assign mmag = msum[PW-1:FRAC_BITS];

    // Restoring division, two quotient bits per cycle.
    always_comb begin
        d_rem = r_rem;
        d_num = r_num;
        d_q   = r_q;
        d_sh  = '0;
        d_ge  = 1'b0;
        for (int j = 0; j < DIV_BITS; j++) begin
            d_sh  = {d_rem, d_num[W-1]};
            d_num = d_num << 1;
            d_ge  = d_sh >= {1'b0, r_y};
            d_q   = {d_q[W-2:0], d_ge};
            d_rem = d_ge ? W'(d_sh - {1'b0, r_y}) : d_sh[W-1:0];
        end
    end

    assign rnd = {r_rem, 1'b0} >= {1'b0, r_y};
    assign q1  = {1'b0, r_q} + (W+1)'(rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= a_mag;
                        r_y     <= b_mag;
                        r_neg   <= i_a[W-1] ^ i_b[W-1];
                        r_aneg  <= i_a[W-1];
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_state <= (i_req.op == ALU_MUL) ? A_MUL : A_DCHK;
                    end
                end
                A_MUL: begin
                    if (r_step != '0) begin
                        r_acc <= r_acc + prod_sh;
                    end
                    if (r_step == MUL_LAST) begin
                        r_state <= A_MFIN;
                    end else begin
                        r_prod <= x_part * y_part;
                        r_psh  <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
                    end
                    r_step <= r_step + 1'b1;
                end
                A_MFIN: begin
                    r_res   <= mag_val(mmag, r_neg);
                    r_sat   <= mag_over(mmag, r_neg);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DCHK: begin
                    if (r_y == '0) begin
                        r_res   <= r_aneg ? VAL_MIN : VAL_MAX;
                        r_sat   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else if ((r_x >> (W - FRAC_BITS)) >= r_y) begin
                        r_res   <= r_neg ? VAL_MIN : VAL_MAX;
                        r_sat   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        r_rem   <= r_x >> (W - FRAC_BITS);
                        r_num   <= r_x << FRAC_BITS;
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    r_rem  <= d_rem;
                    r_num  <= d_num;
                    r_q    <= d_q;
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST) begin
                        r_state <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    r_res   <= mag_val(RW'(q1), r_neg);
                    r_sat   <= mag_over(RW'(q1), r_neg);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_result   = r_res;

endmodule

FILE: dv/tridiagonal_thomas_solver_tb.sv
// Self-checking testbench for the tridiagonal Thomas-algorithm solver.
// Depends on tds_pkg and tridiagonal_thomas_solver; runs stand-alone.
module tridiagonal_thomas_solver_tb;
    import tds_pkg::*;

    typedef logic signed [W-1:0] t_val;

    // One row of the directed stimulus. Where a row ends a solve, chk_val and
    // chk_sat say which fields of every word of that solve are typed in here.
    typedef struct {
        logic   op;
        int     idx;
        t_val   diag;
        t_val   upper;
        t_val   lower;
        t_val   rhs;
        bit     chk_val;
        t_val   val;
        bit     chk_sat;
        bit     sat;
    } t_row;

    // An expected solution word, with optional hand-written values attached.
    typedef struct {
        t_out_item item;
        bit        chk_val;
        t_val      tval;
        bit        chk_sat;
        bit        tsat;
    } t_expect;

    localparam t_val ONE  = 48'sh0001_0000_0000;
    localparam t_val FIVE = 48'sh0005_0000_0000;
    localparam int   LONG_HOLD = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    tridiagonal_thomas_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the solver state, kept in step with every accepted
    // word. The *_ok flags record which store entries hold defined data, so
    // that the random part never makes the block read an unwritten entry.
    // ------------------------------------------------------------------
    t_val pivot_mem [MAX_POINTS];
    t_val ratio_mem [MAX_POINTS];
    t_val lower_mem [MAX_POINTS];
    t_val sweep_mem [MAX_POINTS];
    bit   pivot_ok  [MAX_POINTS];
    bit   ratio_ok  [MAX_POINTS];
    bit   lower_ok  [MAX_POINTS];
    bit   sweep_ok  [MAX_POINTS];
    t_val last_ratio;
    t_val last_fwd;
    bit   solve_sat;
    bit   factor_sat;
    bit   step_sat;
    logic [CFG_W-1:0] size_reg;

    t_expect solution_q[$];
    bit      typed_val;
    t_val    typed_v;
    bit      typed_sat;
    bit      typed_s;

    int  mismatches;
    int  words_used;
    int  words_ignored;
    int  solves_seen;
    int  results_seen;
    bit  calm;
    bit  hold_req;

    function automatic int grid_size();
        if (size_reg < MIN_POINTS) return MIN_POINTS;
        if (size_reg > MAX_POINTS) return MAX_POINTS;
        return int'(size_reg);
    endfunction

    function automatic t_val clip(longint v);
        if (v > longint'(VAL_MAX)) begin
            step_sat = 1'b1;
            return VAL_MAX;
        end
        if (v < longint'(VAL_MIN)) begin
            step_sat = 1'b1;
            return VAL_MIN;
        end
        return t_val'(v);
    endfunction

    function automatic logic [63:0] magnitude(t_val v);
        return (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
    endfunction

    // Signed result from a rounded magnitude, saturating on overflow.
    function automatic t_val signed_of(logic [127:0] m, bit neg);
        if (neg) begin
            if (m > (128'd1 << 47)) begin
                step_sat = 1'b1;
                return VAL_MIN;
            end
            return t_val'(~m[W-1:0] + 48'd1);
        end
        if (m > 128'(VAL_MAX)) begin
            step_sat = 1'b1;
            return VAL_MAX;
        end
        return t_val'(m[W-1:0]);
    endfunction

    function automatic t_val q_sub(t_val a, t_val b);
        return clip(longint'(a) - longint'(b));
    endfunction

    // Fixed-point product, rounded to nearest with ties away from zero.
    function automatic t_val q_mul(t_val a, t_val b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return signed_of(p, (a < 0) != (b < 0));
    endfunction

    // Fixed-point quotient; a zero divisor saturates towards the sign of a.
    function automatic t_val q_div(t_val a, t_val b);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        if (b == 0) begin
            step_sat = 1'b1;
            return (a < 0) ? VAL_MIN : VAL_MAX;
        end
        num = {64'd0, magnitude(a)} << FRAC_BITS;
        den = {64'd0, magnitude(b)};
        quo = num / den;
        rem = num % den;
        if (quo < (128'd1 << W) && rem >= den - rem) quo = quo + 1;
        return signed_of(quo, (a < 0) != (b < 0));
    endfunction

    // True when the word would only read store entries that hold data.
    function automatic bit reads_defined(t_in_item w);
        int n;
        int i;
        n = grid_size();
        i = int'(w.index);
        if (i >= n) return 1'b1;
        if (w.operation == OP_LOAD) return (i == 0) || lower_ok[i-1];
        if (!pivot_ok[i] || (i > 0 && !lower_ok[i-1])) return 1'b0;
        if (i == n - 1) begin
            for (int k = 1; k <= n - 2; k++)
                if (!ratio_ok[k] || !sweep_ok[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the shadow state by one accepted word and queues the solution
    // words that it releases.
    function automatic void solve_step(t_in_item w);
        int n;
        int i;
        t_val piv;
        t_val v;
        t_expect e;
        n = grid_size();
        i = int'(w.index);
        if (i >= n) begin
            words_ignored++;
            return;
        end
        words_used++;
        step_sat = 1'b0;
        if (w.operation == OP_LOAD) begin
            if (i == 0) begin
                factor_sat = 1'b0;
                solve_sat  = 1'b0;
                piv = w.diag_coef;
            end else begin
                piv = q_sub(w.diag_coef, q_mul(lower_mem[i-1], last_ratio));
            end
            pivot_mem[i] = piv;
            pivot_ok[i]  = 1'b1;
            lower_mem[i] = w.lower_coef;
            lower_ok[i]  = 1'b1;
            if (i < n - 1) begin
                last_ratio   = q_div(w.upper_coef, piv);
                ratio_mem[i] = last_ratio;
                ratio_ok[i]  = 1'b1;
            end
            if (step_sat) begin
                factor_sat = 1'b1;
                solve_sat  = 1'b1;
            end
            return;
        end
        if (i == 0) begin
            solve_sat = factor_sat;
            v = q_div(w.rhs_value, pivot_mem[0]);
        end else begin
            v = q_div(q_sub(w.rhs_value, q_mul(lower_mem[i-1], last_fwd)), pivot_mem[i]);
        end
        sweep_mem[i] = v;
        sweep_ok[i]  = 1'b1;
        last_fwd     = v;
        if (i == n - 1) begin
            // Back substitution, then both ends by linear extrapolation.
            for (int k = n - 2; k > 0; k--)
                sweep_mem[k] = q_sub(sweep_mem[k], q_mul(ratio_mem[k], sweep_mem[k+1]));
            sweep_mem[0] = clip(2 * longint'(sweep_mem[1]) - longint'(sweep_mem[2]));
            sweep_mem[n-1] = clip(2 * longint'(sweep_mem[n-2]) - longint'(sweep_mem[n-3]));
            for (int k = 0; k < n; k++) sweep_ok[k] = 1'b1;
        end
        if (step_sat) solve_sat = 1'b1;
        if (i != n - 1) return;
        solves_seen++;
        for (int k = 0; k < n; k++) begin
            e.item.result_index   = 6'(k);
            e.item.solution_value = sweep_mem[k];
            e.item.saturated      = solve_sat;
            e.item.last_result    = (k == n - 1);
            e.chk_val = typed_val;
            e.tval    = typed_v;
            e.chk_sat = typed_sat;
            e.tsat    = typed_s;
            solution_q.push_back(e);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coefficient or right-hand-side value. Mode 0 gives well-conditioned
    // values, mode 1 arbitrary bit patterns, mode 2 small values and zeros.
    function automatic t_val pick_value(int mode, bit dominant);
        longint v;
        case (mode)
            0: begin
                v = longint'($urandom_range(0, 32'hFFFF_FFFF));
                if (dominant) v = v + (longint'($urandom_range(2, 4)) << 32);
                else v = v >>> $urandom_range(0, 2);
            end
            1: begin
                v = {$urandom, $urandom};
            end
            default: begin
                v = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 255)) << 24;
            end
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return t_val'(v);
    endfunction

    function automatic t_in_item make_word(logic op, int idx, int mode);
        t_in_item w;
        w.operation  = op;
        w.index      = 6'(idx);
        w.diag_coef  = pick_value(mode, 1'b1);
        w.upper_coef = pick_value(mode, 1'b0);
        w.lower_coef = pick_value(mode, 1'b0);
        w.rhs_value  = pick_value(mode, 1'b0);
        return w;
    endfunction

    // Offers one word, leaving valid high afterwards; the next call either
    // replaces the payload at once or lowers valid for a gap first.
    task automatic send_word(t_in_item w);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        solve_step(w);
    endtask

    // Lowers valid and waits until every solution word has been taken.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (solution_q.size() == 0);
    endtask

    // Size writes happen only with the block idle; the pause covers a word
    // that is still being factored when the last solution word has left.
    task automatic write_size(logic [CFG_W-1:0] v);
        drain();
        repeat (100) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_row(t_row r);
        t_in_item w;
        w.operation  = r.op;
        w.index      = 6'(r.idx);
        w.diag_coef  = r.diag;
        w.upper_coef = r.upper;
        w.lower_coef = r.lower;
        w.rhs_value  = r.rhs;
        typed_val = r.chk_val;
        typed_v   = r.val;
        typed_sat = r.chk_sat;
        typed_s   = r.sat;
        send_word(w);
        typed_val = 1'b0;
        typed_sat = 1'b0;
    endtask

    task automatic note_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, with one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Each solution word taken is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (solution_q.size() == 0) begin
                note_mismatch("unexpected word, index", o_out_item.result_index, -1);
            end else begin
                e = solution_q.pop_front();
                if (o_out_item.result_index !== e.item.result_index)
                    note_mismatch("result_index", o_out_item.result_index,
                                  e.item.result_index);
                if (o_out_item.solution_value !== e.item.solution_value)
                    note_mismatch("solution_value", o_out_item.solution_value,
                                  e.item.solution_value);
                if (o_out_item.saturated !== e.item.saturated)
                    note_mismatch("saturated", o_out_item.saturated, e.item.saturated);
                if (o_out_item.last_result !== e.item.last_result)
                    note_mismatch("last_result", o_out_item.last_result,
                                  e.item.last_result);
                if (e.chk_val && o_out_item.solution_value !== e.tval)
                    note_mismatch("hand-set solution_value", o_out_item.solution_value,
                                  e.tval);
                if (e.chk_sat && o_out_item.saturated !== e.tsat)
                    note_mismatch("hand-set saturated", o_out_item.saturated, e.tsat);
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("Timeout with %0d words still expected", solution_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        t_row     rows[$];
        t_in_item w;
        int       n;
        int       mode;
        int       vecs;
        int       phase;
        logic [CFG_W-1:0] sz;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        typed_val   = 1'b0;
        typed_sat   = 1'b0;
        typed_v     = '0;
        typed_s     = 1'b0;
        mismatches  = 0;
        words_used  = 0;
        words_ignored = 0;
        solves_seen = 0;
        results_seen = 0;
        size_reg    = 7'd64;
        last_ratio  = '0;
        last_fwd    = '0;
        solve_sat   = 1'b0;
        factor_sat  = 1'b0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            pivot_ok[k] = 1'b0;
            ratio_ok[k] = 1'b0;
            lower_ok[k] = 1'b0;
            sweep_ok[k] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on a three-point grid.
        write_size(7'd3);
        // Identity matrix with a constant right-hand side returns it unchanged.
        rows.push_back('{OP_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 1, ONE, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 2, ONE, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 0, 0, 0, 0, FIVE, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 1, 0, 0, 0, FIVE, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 2, 0, 0, 0, FIVE, 1, FIVE, 1, 0});
        // Positions beyond the grid are dropped.
        rows.push_back('{OP_LOAD, 63, ONE, ONE, ONE, ONE, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 3, ONE, ONE, ONE, ONE, 0, 0, 0, 0});
        // A zero first pivot must raise the flag on every word of the solve.
        rows.push_back('{OP_LOAD, 0, 0, ONE, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 1, ONE, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 2, ONE, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 0, 0, 0, 0, VAL_MAX, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 1, 0, 0, 0, ONE, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 2, 0, 0, 0, ONE, 0, 0, 1, 1});
        // Extreme coefficients and right-hand sides.
        rows.push_back('{OP_LOAD, 0, VAL_MIN, VAL_MAX, VAL_MIN, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 1, VAL_MAX, VAL_MIN, VAL_MAX, 0, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 2, ONE, VAL_MAX, 0, 0, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 0, 0, 0, 0, VAL_MIN, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 1, 0, 0, 0, VAL_MAX, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 2, 0, 0, 0, 0, 0, 0, 0, 0});
        // Out of order: a repeated element and a reloaded row.
        rows.push_back('{OP_RHS, 1, 0, 0, 0, -FIVE, 0, 0, 0, 0});
        rows.push_back('{OP_LOAD, 2, FIVE, -ONE, ONE, 0, 0, 0, 0, 0});
        rows.push_back('{OP_RHS, 2, 0, 0, 0, ONE, 0, 0, 0, 0});
        foreach (rows[k]) run_row(rows[k]);

        // Random part: each phase sets a size, loads a matrix and solves one
        // or more right-hand sides, with some stray words mixed in.
        phase = 0;
        while (words_used < 130 + 23 || phase < 4) begin
            case (phase)
                0: sz = 7'd127;
                1: sz = 7'd0;
                default: sz = 7'($urandom_range(1, 12));
            endcase
            write_size(sz);
            n = grid_size();
            calm = (phase % 4 == 3);
            mode = $urandom_range(0, 9);
            mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
            for (int i = 0; i < n; i++) send_word(make_word(OP_LOAD, i, mode));
            vecs = (phase == 1) ? 3 : $urandom_range(1, 3);
            for (int v = 0; v < vecs; v++) begin
                for (int i = 0; i < n; i++) begin
                    // Hold the receiver off while the next vector keeps coming,
                    // so that the held output run stalls the block's input.
                    if (phase == 1 && v == 0 && i == n - 1) hold_req = 1'b1;
                    send_word(make_word(OP_RHS, i, (mode == 1) ? 1 : 0));
                end
                if ($urandom_range(0, 3) == 0) drain();
            end
            repeat ($urandom_range(0, 5)) begin
                w = make_word(logic'($urandom_range(0, 1)), $urandom_range(0, 63),
                              $urandom_range(0, 2));
                if (reads_defined(w)) send_word(w);
            end
            phase++;
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d solves and %0d solution words from %0d words in use",
                 solves_seen, results_seen, words_used);
        $display("(%0d words outside the grid were dropped, %0d size settings).",
                 words_ignored, phase + 1);
        if (mismatches == 0 && solution_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
